// ===== rtl/fprs_pkg.sv =====
`timescale 1ns / 1ps

package fprs_pkg;

  // Sizes of the ring, the key space and the record store.
  localparam int RING_DEPTH = 64;
  localparam int CHANNELS   = 2;
  localparam int ID_SPACE   = 2048;
  localparam int MAX_REC    = 63;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int KEY_N      = CHANNELS * ID_SPACE;
  localparam int KEY_AW     = $clog2(KEY_N);
  localparam int REC_AW     = $clog2(MAX_REC + 1);

  // Age in ms is floor(us / 1000): exact by reciprocal for inputs below 2^26.
  localparam int          AGE_IN_W  = 26;
  localparam int          AGE_SHIFT = 36;
  localparam logic [26:0] AGE_RECIP = 27'd68719477;
  localparam logic [15:0] AGE_MAX   = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_COLLECT = 2'd1,
    OP_SUMMARY = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] frame_time_us;
    logic [7:0]  bus_channel;
    logic [28:0] ident;
    logic [3:0]  length;
    logic [63:0] payload;
    logic [63:0] now_time_us;
    logic [31:0] lookback_us;
    logic [5:0]  max_out;
    logic [11:0] skip_count;
  } in_item_t;

  typedef struct packed {
    logic        is_record;
    logic        last_item;
    logic [7:0]  out_channel;
    logic [28:0] out_ident;
    logic [3:0]  out_length;
    logic [63:0] out_payload;
    logic [63:0] out_time_us;
    logic [15:0] first_age_ms;
    logic [15:0] last_age_ms;
    logic [15:0] frame_total;
    logic [15:0] change_total;
  } out_item_t;

  // One stored bus frame.
  typedef struct packed {
    logic [63:0] time_us;
    logic [3:0]  len;
    logic [28:0] ident;
    logic [7:0]  channel;
    logic [63:0] data;
  } ring_entry_t;

  // One summary record.
  typedef struct packed {
    logic [7:0]  channel;
    logic [28:0] ident;
    logic [3:0]  len;
    logic [63:0] data;
    logic [15:0] first_age;
    logic [15:0] last_age;
    logic [15:0] frames;
    logic [15:0] changes;
  } rec_t;

  // Per-key entry: key seen in this summary, and its record if it has one.
  typedef struct packed {
    logic              seen;
    logic              has_rec;
    logic [REC_AW-1:0] idx;
  } map_entry_t;

  typedef struct packed {
    logic load;
    logic push;
    logic ring_rd;
    logic adv;
    logic rewind;
    logic c_take;
    logic c_flush;
    logic map_rd;
    logic mark_skip;
    logic mark_only;
    logic new_rec;
    logic old_rec;
    logic rec_wr;
    logic e_rd;
    logic e_out;
    logic e_adv;
    logic empty_out;
    logic map_clr;
    logic clr_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic fill_zero;
    logic cap_zero;
    logic walk_last;
    logic in_win;
    logic key_ok;
    logic map_seen;
    logic map_rec;
    logic skip_more;
    logic cap_full;
    logic cap_hit;
    logic n_zero;
    logic e_last;
    logic clr_last;
  } ctrl_stat_t;

  // Clamp a raw length code to at most eight bytes.
  function automatic logic [3:0] clamp_len(input logic [3:0] n);
    clamp_len = (n > 4'd8) ? 4'd8 : n;
  endfunction

  // Mask covering the first n bytes, n at most eight.
  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < n) begin
        m[b*8 +: 8] = 8'hFF;
      end
    end
    byte_mask = m;
  endfunction

endpackage

// ===== rtl/fprs_ctrl.sv =====
`timescale 1ns / 1ps

module fprs_ctrl
  import fprs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] opcode,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd,
  output logic       busy
);

  typedef enum logic [15:0] {
    ST_IDLE   = 16'b0000000000000001,
    ST_CLR    = 16'b0000000000000010,
    ST_CSTART = 16'b0000000000000100,
    ST_CREAD  = 16'b0000000000001000,
    ST_CCHK   = 16'b0000000000010000,
    ST_CFLUSH = 16'b0000000000100000,
    ST_SSTART = 16'b0000000001000000,
    ST_SREAD  = 16'b0000000010000000,
    ST_SMAP   = 16'b0000000100000000,
    ST_SREC   = 16'b0000001000000000,
    ST_SAGE   = 16'b0000010000000000,
    ST_EREAD  = 16'b0000100000000000,
    ST_EOUT   = 16'b0001000000000000,
    ST_SEMPTY = 16'b0010000000000000,
    ST_WREAD  = 16'b0100000000000000,
    ST_WCLR   = 16'b1000000000000000
  } state_t;

  state_t state_r, state_nxt;

  // State register; reset starts the sweep that clears the key map.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  // Next state and commands to the datapath.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (opcode)
            OP_PUSH:    cmd.push = 1'b1;
            OP_COLLECT: begin
              cmd.load  = 1'b1;
              state_nxt = ST_CSTART;
            end
            OP_SUMMARY: begin
              cmd.load  = 1'b1;
              state_nxt = ST_SSTART;
            end
            default: ;
          endcase
        end
      end
      ST_CLR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CSTART: begin
        state_nxt = (stat.fill_zero || stat.cap_zero) ? ST_CFLUSH : ST_CREAD;
      end
      ST_CREAD: begin
        cmd.ring_rd = 1'b1;
        state_nxt   = ST_CCHK;
      end
      ST_CCHK: begin
        cmd.c_take = stat.in_win;
        if ((stat.in_win && stat.cap_hit) || stat.walk_last) begin
          state_nxt = ST_CFLUSH;
        end else begin
          cmd.adv   = 1'b1;
          state_nxt = ST_CREAD;
        end
      end
      ST_CFLUSH: begin
        cmd.c_flush = 1'b1;
        state_nxt   = ST_IDLE;
      end
      ST_SSTART: begin
        state_nxt = stat.fill_zero ? ST_SEMPTY : ST_SREAD;
      end
      ST_SREAD: begin
        cmd.ring_rd = 1'b1;
        state_nxt   = ST_SMAP;
      end
      ST_SMAP: begin
        cmd.map_rd = 1'b1;
        if (stat.in_win && stat.key_ok) begin
          state_nxt = ST_SREC;
        end else if (stat.walk_last) begin
          cmd.rewind = 1'b1;
          state_nxt  = stat.n_zero ? ST_SEMPTY : ST_EREAD;
        end else begin
          cmd.adv   = 1'b1;
          state_nxt = ST_SREAD;
        end
      end
      ST_SREC: begin
        priority if (stat.map_seen && stat.map_rec) begin
          cmd.old_rec = 1'b1;
          state_nxt   = ST_SAGE;
        end else if (!stat.map_seen && !stat.skip_more && !stat.cap_full) begin
          cmd.new_rec = 1'b1;
          state_nxt   = ST_SAGE;
        end else begin
          // Key already passed over, skipped now, or no room for a record.
          cmd.mark_skip = !stat.map_seen && stat.skip_more;
          cmd.mark_only = !stat.map_seen && !stat.skip_more;
          if (stat.walk_last) begin
            cmd.rewind = 1'b1;
            state_nxt  = stat.n_zero ? ST_SEMPTY : ST_EREAD;
          end else begin
            cmd.adv   = 1'b1;
            state_nxt = ST_SREAD;
          end
        end
      end
      ST_SAGE: begin
        cmd.rec_wr = 1'b1;
        if (stat.walk_last) begin
          cmd.rewind = 1'b1;
          state_nxt  = ST_EREAD;
        end else begin
          cmd.adv   = 1'b1;
          state_nxt = ST_SREAD;
        end
      end
      ST_EREAD: begin
        cmd.e_rd  = 1'b1;
        state_nxt = ST_EOUT;
      end
      ST_EOUT: begin
        cmd.e_out = 1'b1;
        if (stat.e_last) begin
          state_nxt = ST_WREAD;
        end else begin
          cmd.e_adv = 1'b1;
          state_nxt = ST_EREAD;
        end
      end
      ST_SEMPTY: begin
        cmd.empty_out = 1'b1;
        state_nxt     = stat.fill_zero ? ST_IDLE : ST_WREAD;
      end
      ST_WREAD: begin
        cmd.ring_rd = 1'b1;
        state_nxt   = ST_WCLR;
      end
      ST_WCLR: begin
        cmd.map_clr = 1'b1;
        if (stat.walk_last) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.adv   = 1'b1;
          state_nxt = ST_WREAD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/fprs_datapath.sv =====
`timescale 1ns / 1ps

module fprs_datapath
  import fprs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_item,
  input  ctrl_cmd_t  cmd,
  output ctrl_stat_t stat,
  output logic       out_strobe,
  output out_item_t  out_item
);

  // Ring, key map and record store.
  ring_entry_t ring_mem [RING_DEPTH];
  map_entry_t  map_mem  [KEY_N];
  rec_t        rec_mem  [MAX_REC];

  logic [RING_AW-1:0] wp_r, fill_r, slot_r, i_r;
  logic [KEY_AW-1:0]  clr_r;
  logic [63:0]        now_r, start_r;
  logic [5:0]         cap_r;
  logic [11:0]        skip_r, skipped_r;
  logic [REC_AW-1:0]  n_r, e_r, rec_idx_r;
  logic               new_r;
  ring_entry_t        ring_q_r, pend_r;
  logic               pend_v_r;
  map_entry_t         map_q_r;
  rec_t               rec_q_r;
  logic [63:0]        diff_r;
  logic               ge_r, hi_r;
  logic [52:0]        prod_r;
  logic               out_strobe_r;
  out_item_t          out_r;

  logic [RING_AW:0]   old_sum;
  logic [RING_AW-1:0] oldest, slot_inc;
  logic [KEY_AW-1:0]  key;
  logic               map_we;
  logic [KEY_AW-1:0]  map_wa;
  map_entry_t         map_wd;
  logic [REC_AW-1:0]  rec_ra;
  logic [3:0]         lc;
  logic [63:0]        mask;
  logic [16:0]        quot;
  logic [15:0]        age;
  logic               differs;
  rec_t               rec_nxt;
  ring_entry_t        push_ent;
  out_item_t          out_nxt;
  logic               out_fire;

  // Oldest slot and the ring step.
  assign old_sum  = {1'b0, wp_r} + (RING_AW+1)'(RING_DEPTH) - {1'b0, fill_r};
  assign oldest   = (old_sum >= (RING_AW+1)'(RING_DEPTH)) ?
                    RING_AW'(old_sum - (RING_AW+1)'(RING_DEPTH)) : old_sum[RING_AW-1:0];
  assign slot_inc = (slot_r == RING_AW'(RING_DEPTH - 1)) ? '0 : slot_r + 1'b1;

  // Key of the frame just read from the ring.
  assign key = KEY_AW'(32'(ring_q_r.channel) * ID_SPACE + 32'(ring_q_r.ident));

  // Status toward the controller.
  always_comb begin
    stat.fill_zero = (fill_r == '0);
    stat.cap_zero  = (cap_r == '0);
    stat.walk_last = (i_r == fill_r - 1'b1);
    stat.in_win    = (ring_q_r.time_us >= start_r) && (ring_q_r.time_us <= now_r);
    stat.key_ok    = (32'(ring_q_r.channel) < CHANNELS) && (32'(ring_q_r.ident) < ID_SPACE);
    stat.map_seen  = map_q_r.seen;
    stat.map_rec   = map_q_r.has_rec;
    stat.skip_more = (skipped_r < skip_r);
    stat.cap_full  = (7'(n_r) >= 7'(cap_r));
    stat.cap_hit   = (7'(n_r) + 7'd1 == 7'(cap_r));
    stat.n_zero    = (n_r == '0);
    stat.e_last    = (e_r == n_r - 1'b1);
    stat.clr_last  = (clr_r == KEY_AW'(KEY_N - 1));
  end

  // Ring pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      fill_r <= '0;
    end else if (cmd.push) begin
      wp_r <= (wp_r == RING_AW'(RING_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (fill_r < RING_AW'(RING_DEPTH - 1)) begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  // Ring memory: one write port for pushes, one registered read port.
  always_comb begin
    push_ent.time_us = in_item.frame_time_us;
    push_ent.len     = in_item.length;
    push_ent.ident   = in_item.ident;
    push_ent.channel = in_item.bus_channel;
    push_ent.data    = in_item.payload;
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      ring_mem[wp_r] <= push_ent;
    end
    if (cmd.ring_rd) begin
      ring_q_r <= ring_mem[slot_r];
    end
  end

  // Query registers and walk counters.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r     <= in_item.now_time_us;
      start_r   <= (in_item.now_time_us > 64'(in_item.lookback_us)) ?
                   in_item.now_time_us - 64'(in_item.lookback_us) : '0;
      cap_r     <= in_item.max_out;
      skip_r    <= in_item.skip_count;
      skipped_r <= '0;
      n_r       <= '0;
      e_r       <= '0;
      slot_r    <= oldest;
      i_r       <= '0;
    end else begin
      if (cmd.adv) begin
        slot_r <= slot_inc;
        i_r    <= i_r + 1'b1;
      end
      if (cmd.rewind) begin
        slot_r <= oldest;
        i_r    <= '0;
      end
      if (cmd.mark_skip) begin
        skipped_r <= skipped_r + 1'b1;
      end
      if (cmd.new_rec || cmd.c_take) begin
        n_r <= n_r + 1'b1;
      end
      if (cmd.e_adv) begin
        e_r <= e_r + 1'b1;
      end
    end
  end

  // Key map clear sweep after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  // Key map write port: sweep, walk-back clear, or marking a key.
  always_comb begin
    map_we = 1'b0;
    map_wa = key;
    map_wd = '0;
    priority if (cmd.clr_step) begin
      map_we = 1'b1;
      map_wa = clr_r;
    end else if (cmd.map_clr) begin
      map_we = stat.key_ok;
    end else if (cmd.mark_skip || cmd.mark_only) begin
      map_we      = 1'b1;
      map_wd.seen = 1'b1;
    end else if (cmd.new_rec) begin
      map_we         = 1'b1;
      map_wd.seen    = 1'b1;
      map_wd.has_rec = 1'b1;
      map_wd.idx     = n_r;
    end else begin
      map_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    if (cmd.map_rd) begin
      map_q_r <= map_mem[key];
    end
  end

  // Age pipeline: difference, then reciprocal multiply.
  always_ff @(posedge clk) begin
    if (cmd.map_rd) begin
      diff_r <= now_r - ring_q_r.time_us;
      ge_r   <= (ring_q_r.time_us >= now_r);
    end
    hi_r   <= |diff_r[63:AGE_IN_W];
    prod_r <= 53'(diff_r[AGE_IN_W-1:0]) * 53'(AGE_RECIP);
  end

  assign quot = prod_r[AGE_SHIFT +: 17];
  assign age  = ge_r ? 16'd0 : ((hi_r || quot[16]) ? AGE_MAX : quot[15:0]);

  // Record update for the current frame.
  assign lc      = clamp_len(ring_q_r.len);
  assign mask    = byte_mask(lc);
  assign differs = (rec_q_r.len != lc) || (((rec_q_r.data ^ ring_q_r.data) & mask) != '0);

  always_comb begin
    rec_nxt = rec_q_r;
    if (new_r) begin
      rec_nxt.channel   = ring_q_r.channel;
      rec_nxt.ident     = ring_q_r.ident;
      rec_nxt.data      = ring_q_r.data & mask;
      rec_nxt.first_age = age;
      rec_nxt.frames    = 16'd1;
      rec_nxt.changes   = 16'd0;
    end else begin
      rec_nxt.data = (rec_q_r.data & ~mask) | (ring_q_r.data & mask);
      if (differs && (rec_q_r.changes != AGE_MAX)) begin
        rec_nxt.changes = rec_q_r.changes + 1'b1;
      end
      if (rec_q_r.frames != AGE_MAX) begin
        rec_nxt.frames = rec_q_r.frames + 1'b1;
      end
    end
    rec_nxt.len      = lc;
    rec_nxt.last_age = age;
  end

  // Record store: registered read for updates and for emission.
  assign rec_ra = cmd.old_rec ? map_q_r.idx : e_r;

  always_ff @(posedge clk) begin
    if (cmd.new_rec || cmd.old_rec) begin
      rec_idx_r <= cmd.new_rec ? n_r : map_q_r.idx;
      new_r     <= cmd.new_rec;
    end
    if (cmd.rec_wr) begin
      rec_mem[rec_idx_r] <= rec_nxt;
    end
    if (cmd.old_rec || cmd.e_rd) begin
      rec_q_r <= rec_mem[rec_ra];
    end
  end

  // Collect holds one frame back so the final one can carry last_item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else if (cmd.load) begin
      pend_v_r <= 1'b0;
    end else if (cmd.c_take) begin
      pend_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.c_take) begin
      pend_r <= ring_q_r;
    end
  end

  // Result item selection.
  always_comb begin
    out_nxt  = '0;
    out_fire = 1'b0;
    priority if (cmd.c_take || cmd.c_flush) begin
      out_fire              = cmd.c_flush || pend_v_r;
      out_nxt.is_record     = pend_v_r;
      out_nxt.last_item     = cmd.c_flush;
      if (pend_v_r) begin
        out_nxt.out_channel = pend_r.channel;
        out_nxt.out_ident   = pend_r.ident;
        out_nxt.out_length  = pend_r.len;
        out_nxt.out_payload = pend_r.data;
        out_nxt.out_time_us = pend_r.time_us;
      end
    end else if (cmd.e_out) begin
      out_fire             = 1'b1;
      out_nxt.is_record    = 1'b1;
      out_nxt.last_item    = stat.e_last;
      out_nxt.out_channel  = rec_q_r.channel;
      out_nxt.out_ident    = rec_q_r.ident;
      out_nxt.out_length   = rec_q_r.len;
      out_nxt.out_payload  = rec_q_r.data;
      out_nxt.first_age_ms = rec_q_r.first_age;
      out_nxt.last_age_ms  = rec_q_r.last_age;
      out_nxt.frame_total  = rec_q_r.frames;
      out_nxt.change_total = rec_q_r.changes;
    end else if (cmd.empty_out) begin
      out_fire          = 1'b1;
      out_nxt.last_item = 1'b1;
    end else begin
      out_fire = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= out_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      out_r <= out_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

endmodule

// ===== rtl/frame_pretrigger_ring_summarizer.sv =====
`timescale 1ns / 1ps

// Channel   Ports                      Handshake
// input     start, busy, in_item       item taken when start is high and busy low
// result    out_strobe, out_item       one cycle per item, cannot be held off
//
// A push is taken without leaving idle, and the next item may follow at once.
// A collect reads and checks each stored frame in turn, then sends its final item.
// A summarize walks the stored frames to build records, sends each record,
// and walks the stored frames again for the key map clean-up; the ring memory
// port and the key map read-modify-write set the pace of these walks.
// After reset busy stays high while the key map is cleared.

module frame_pretrigger_ring_summarizer
  import fprs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  // Sequencer.
  fprs_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .opcode (in_item.opcode),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Storage and arithmetic.
  fprs_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cmd        (cmd),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

`ifndef SYNTHESIS
  // The final item of a query is never directly followed by another.
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.last_item |=> !out_strobe)
    else $error("result item right after the final item of a query");

  // An empty answer is always the final item.
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_item.is_record |-> out_item.last_item)
    else $error("empty answer without last_item");

  // Reset starts the key map sweep, so no item is taken right after it.
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> busy)
    else $error("block not busy after reset");
`endif

endmodule
